[hdl/mutex_owner_fifo_waiters_assert.svh]
// assertion macros for the lock unit
`ifndef MUTEX_OWNER_FIFO_WAITERS_ASSERT_SVH
`define MUTEX_OWNER_FIFO_WAITERS_ASSERT_SVH

// same-cycle implication
`define MOFW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mofw assertion failed");

// next-cycle implication
`define MOFW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mofw assertion failed");

`endif

[hdl/mofw_pkg.sv]
`default_nettype none
package mofw_pkg;

   localparam int TID_W    = 4;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_WAIT    = 2'd0,
      KIND_SIGNAL  = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACQUIRED         = 4'd0,
      ST_BUSY_NOWAIT      = 4'd1,
      ST_ALREADY_OWNER    = 4'd2,
      ST_QUEUED           = 4'd3,
      ST_QUEUE_FULL       = 4'd4,
      ST_NOT_OWNER        = 4'd5,
      ST_HANDED_OVER      = 4'd6,
      ST_RELEASED         = 4'd7,
      ST_TIMED_OUT        = 4'd8,
      ST_ALREADY_SIGNALED = 4'd9
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic             shift_all;
      logic             shift_found;
      logic             append;
      logic [TID_W-1:0] tid;
   } cell_ctrl_type;

endpackage
`default_nettype wire

[hdl/mofw_if.sv]
`default_nettype none
interface mofw_req_if import mofw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [TID_W-1:0]  thread_id;
   logic              no_wait;

   modport source (output valid, kind, thread_id, no_wait, input ready);
   modport sink   (input valid, kind, thread_id, no_wait, output ready);
endinterface

interface mofw_rsp_if import mofw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                owner_valid;
   logic [TID_W-1:0]    owner_thread;
   logic                woken_valid;
   logic [TID_W-1:0]    woken_thread;

   modport source (output valid, status, owner_valid, owner_thread, woken_valid,
                   woken_thread, input ready);
   modport sink   (input valid, status, owner_valid, owner_thread, woken_valid,
                   woken_thread, output ready);
endinterface
`default_nettype wire

[hdl/mutex_owner_fifo_waiters.sv]
// lock unit with owner register and a row of waiter cells
// the request is captured in the idle state and executed in the exec state; the result is registered
// a new request is accepted only in the idle state; execution waits while an earlier result is stalled
// the queue updates through the cell row, which shifts and appends
// reset (synchronous): lock free, owner zero, queue empty; cell contents not cleared
`default_nettype none
module mutex_owner_fifo_waiters import mofw_pkg::*; #(
   parameter int MAX_THREADS = 16
) (
   input wire logic clock,
   input wire logic reset,
   mofw_req_if.sink   req_ch,
   mofw_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(MAX_THREADS + 1);

   state_type         state_ff, state_in;
   logic              held_ff, held_in;
   logic [TID_W-1:0]  owner_ff, owner_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [TID_W-1:0]  tid_ff, tid_in;
   logic              nowait_ff, nowait_in;
   status_type        status_ff, status_in;
   logic              own_v_ff, own_v_in;
   logic [TID_W-1:0]  own_t_ff, own_t_in;
   logic              woke_ff, woke_in;
   logic [TID_W-1:0]  woken_ff, woken_in;

   cell_ctrl_type     ctrl;
   logic [TID_W-1:0]  cell_id [MAX_THREADS];
   logic [MAX_THREADS:0] found_chain;
   logic              queue_full;
   logic              queue_empty;

   assign found_chain[0] = 1'b0;
   assign queue_full     = count_ff == CNT_W'(MAX_THREADS);
   assign queue_empty    = count_ff == '0;

   for (genvar gi = 0; gi < MAX_THREADS; gi++) begin : g_cell
      logic [TID_W-1:0] right_id;
      if (gi == MAX_THREADS - 1) begin : g_last
         assign right_id = cell_id[gi];
      end else begin : g_mid
         assign right_id = cell_id[gi+1];
      end
      mofw_cell #(
         .INDEX (gi),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .id_right  (right_id),
         .found_in  (found_chain[gi]),
         .found_out (found_chain[gi+1]),
         .id_out    (cell_id[gi])
      );
   end

   assign req_ch.ready        = state_ff == S_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.owner_valid  = own_v_ff;
   assign rsp_ch.owner_thread = own_t_ff;
   assign rsp_ch.woken_valid  = woke_ff;
   assign rsp_ch.woken_thread = woken_ff;

   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      owner_in     = owner_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      kind_in      = kind_ff;
      tid_in       = tid_ff;
      nowait_in    = nowait_ff;
      status_in    = status_ff;
      own_v_in     = own_v_ff;
      own_t_in     = own_t_ff;
      woke_in      = woke_ff;
      woken_in     = woken_ff;
      ctrl         = '{shift_all: 1'b0, shift_found: 1'b0, append: 1'b0, tid: tid_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               kind_in   = req_ch.kind;
               tid_in    = req_ch.thread_id;
               nowait_in = req_ch.no_wait;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               woke_in  = 1'b0;
               woken_in = '0;
               unique case (kind_ff)
                  KIND_WAIT: begin
                     priority if (!held_ff) begin
                        held_in   = 1'b1;
                        owner_in  = tid_ff;
                        status_in = ST_ACQUIRED;
                     end else if (nowait_ff) begin
                        status_in = ST_BUSY_NOWAIT;
                     end else if (owner_ff == tid_ff) begin
                        status_in = ST_ALREADY_OWNER;
                     end else if (queue_full) begin
                        status_in = ST_QUEUE_FULL;
                     end else begin
                        ctrl.append = 1'b1;
                        count_in    = count_ff + 1'b1;
                        status_in   = ST_QUEUED;
                     end
                  end
                  KIND_SIGNAL: begin
                     priority if (!held_ff || (owner_ff != tid_ff)) begin
                        status_in = ST_NOT_OWNER;
                     end else if (!queue_empty) begin
                        ctrl.shift_all = 1'b1;
                        count_in       = count_ff - 1'b1;
                        owner_in       = cell_id[0];
                        woke_in        = 1'b1;
                        woken_in       = cell_id[0];
                        status_in      = ST_HANDED_OVER;
                     end else begin
                        held_in   = 1'b0;
                        owner_in  = '0;
                        status_in = ST_RELEASED;
                     end
                  end
                  KIND_TIMEOUT: begin
                     if (found_chain[MAX_THREADS]) begin
                        ctrl.shift_found = 1'b1;
                        count_in         = count_ff - 1'b1;
                        status_in        = ST_TIMED_OUT;
                     end else begin
                        status_in = ST_ALREADY_SIGNALED;
                     end
                  end
                  default: begin
                     status_in = ST_NOT_OWNER;
                  end
               endcase
               own_v_in     = held_in;
               own_t_in     = held_in ? owner_in : '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= 1'b0;
         owner_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         owner_ff     <= owner_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      tid_ff    <= tid_in;
      nowait_ff <= nowait_in;
      status_ff <= status_in;
      own_v_ff  <= own_v_in;
      own_t_ff  <= own_t_in;
      woke_ff   <= woke_in;
      woken_ff  <= woken_in;
   end

endmodule
`default_nettype wire

[hdl/mofw_cell.sv]
`default_nettype none
module mofw_cell import mofw_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  wire logic             clock,
   input  wire cell_ctrl_type    ctrl,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic [TID_W-1:0] id_right,
   input  wire logic             found_in,
   output      logic             found_out,
   output      logic [TID_W-1:0] id_out
);

   logic [TID_W-1:0] id_ff;
   logic [TID_W-1:0] id_in;
   logic             occupied;
   logic             match;

   assign occupied  = count > CNT_W'(INDEX);
   assign match     = occupied && (id_ff == ctrl.tid);
   assign found_out = found_in || match;
   assign id_out    = id_ff;

   always_comb begin
      priority if (ctrl.shift_all || (ctrl.shift_found && found_out)) begin
         id_in = id_right;
      end else if (ctrl.append && (count == CNT_W'(INDEX))) begin
         id_in = ctrl.tid;
      end else begin
         id_in = id_ff;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

endmodule
`default_nettype wire

[hdl/mofw_checker.sv]
`default_nettype none
`include "mutex_owner_fifo_waiters_assert.svh"
module mofw_checker import mofw_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] status,
   input wire logic                owner_valid,
   input wire logic [TID_W-1:0]    owner_thread,
   input wire logic                woken_valid,
   input wire logic [TID_W-1:0]    woken_thread
);

   // stalled result holds
   `MOFW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(owner_thread) && $stable(woken_thread))

   // free lock shows no owner
   `MOFW_ASSERT_NOW(a_free_owner_zero, clock, reset, rsp_valid && !owner_valid, owner_thread == '0)

   // wake only on hand-over, and the woken thread becomes owner
   `MOFW_ASSERT_NOW(a_woken_handover, clock, reset, rsp_valid && woken_valid, (status == ST_HANDED_OVER) && owner_valid && (owner_thread == woken_thread))

   // grants leave an owner, release leaves none
   `MOFW_ASSERT_NOW(a_grant_owner, clock, reset, rsp_valid && ((status == ST_ACQUIRED) || (status == ST_RELEASED)), owner_valid == (status == ST_ACQUIRED))

endmodule

bind mutex_owner_fifo_waiters mofw_checker u_mofw_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .status       (rsp_ch.status),
   .owner_valid  (rsp_ch.owner_valid),
   .owner_thread (rsp_ch.owner_thread),
   .woken_valid  (rsp_ch.woken_valid),
   .woken_thread (rsp_ch.woken_thread)
);
`default_nettype wire
